[rtl/mavg_db_pkg.sv]
// Package: constants, types and register codes for the moving-average deadband filter.
package mavg_db_pkg;

  localparam int AVERAGE_DEPTH = 16;
  localparam int IDX_W         = $clog2(AVERAGE_DEPTH);
  localparam int SUM_W         = 8 + $clog2(AVERAGE_DEPTH + 1);
  localparam int PROG_W        = 9;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [7:0] FORCE_OFFSET  = 8'd100;
  localparam logic [7:0] FULL_SCALE    = 8'd255;
  localparam logic [7:0] WARMUP_RESET  = 8'd16;

  typedef enum logic [1:0] {
    REG_MIN_CHANGE   = 2'd0,
    REG_STICK_MARGIN = 2'd1,
    REG_WARMUP_COUNT = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] min_change;
    logic [7:0] stick_margin;
    logic [7:0] warmup_count;
  } cfg_t;

endpackage

[rtl/mavg_db_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mavg_db_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/mavg_db_cfg.sv]
// Configuration register file behind the APB-style port.
module mavg_db_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mavg_db_pkg::ADDR_W-1:0] paddr,
  input  logic [mavg_db_pkg::DATA_W-1:0] pwdata,
  output logic [mavg_db_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output mavg_db_pkg::cfg_t             cfg
);
  import mavg_db_pkg::*;

  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_change   <= 8'd0;
      cfg.stick_margin <= 8'd0;
      cfg.warmup_count <= WARMUP_RESET;
    end else if (wr_en) begin
      case (index)
        REG_MIN_CHANGE:   cfg.min_change   <= pwdata[7:0];
        REG_STICK_MARGIN: cfg.stick_margin <= pwdata[7:0];
        REG_WARMUP_COUNT: cfg.warmup_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_MIN_CHANGE:   prdata = {{(DATA_W-8){1'b0}}, cfg.min_change};
      REG_STICK_MARGIN: prdata = {{(DATA_W-8){1'b0}}, cfg.stick_margin};
      REG_WARMUP_COUNT: prdata = {{(DATA_W-8){1'b0}}, cfg.warmup_count};
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/moving_average_deadband_filter.sv]
// Top level: sample ring in RAM, running sum, deadband and end snapping.
// An accepted item is first registered in the ring stage; result_valid is set when that item advances.
// Throughput: one item per cycle, lower only while result_stall holds the ring stage;
// the RAM is read at accept and written back at the same slot when the item advances.
// Reset clears the sum, pointer, warm-up progress, held value and the per-entry valid bits
// of the ring (an unwritten entry reads as zero); no clearing pass is needed.
module moving_average_deadband_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mavg_db_pkg::ADDR_W-1:0] paddr,
  input  logic [mavg_db_pkg::DATA_W-1:0] pwdata,
  output logic [mavg_db_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [7:0]                    sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    average,
  output logic [7:0]                    change_amount,
  output logic [7:0]                    held_value,
  output logic                          warming
);
  import mavg_db_pkg::*;

  cfg_t cfg;

  logic                     accept;
  logic                     advance;
  logic [IDX_W-1:0]         ptr;
  logic [IDX_W-1:0]         ptr_next;
  logic [AVERAGE_DEPTH-1:0] filled;
  logic                     p1_valid;
  logic [7:0]               p1_sample;
  logic [IDX_W-1:0]         p1_addr;
  logic                     p1_filled;
  logic [7:0]               rd_data;
  logic [SUM_W-1:0]         running_sum;
  logic [SUM_W-1:0]         sum_next;
  logic [PROG_W-1:0]        progress;
  logic [7:0]               last_held;
  logic [7:0]               held_next;
  logic [7:0]               old_sample;
  logic [7:0]               mean;
  logic [7:0]               base;
  logic [7:0]               diff;
  logic [7:0]               change;
  logic [7:0]               held_dead;
  logic [7:0]               held_low;
  logic                     is_warm;
  logic                     is_forced;
  logic                     upd;

  mavg_db_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mavg_db_ram #(
    .WIDTH (8),
    .DEPTH (AVERAGE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (p1_addr),
    .wr_data (p1_sample),
    .rd_en   (accept),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  assign advance      = p1_valid && (!result_valid || !result_stall);
  assign sample_stall = p1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;
  assign ptr_next     = (ptr == IDX_W'(AVERAGE_DEPTH - 1)) ? '0 : ptr + 1'b1;

  always_comb begin
    old_sample = p1_filled ? rd_data : 8'd0;
    sum_next   = running_sum - SUM_W'(old_sample) + SUM_W'(p1_sample);
    mean       = 8'(sum_next / SUM_W'(AVERAGE_DEPTH));
    is_warm    = progress < PROG_W'(cfg.warmup_count);
    is_forced  = progress == PROG_W'(cfg.warmup_count);
    base       = is_forced ? mean - FORCE_OFFSET : last_held;
    diff       = (mean > base) ? mean - base : base - mean;
    upd        = diff > cfg.min_change;
    change     = upd ? diff : 8'd0;
    held_dead  = upd ? mean : base;
    held_low   = (held_dead < cfg.stick_margin) ? 8'd0 : held_dead;
    held_next  = (held_low > FULL_SCALE - cfg.stick_margin) ? FULL_SCALE : held_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr          <= '0;
      filled       <= '0;
      p1_valid     <= 1'b0;
      running_sum  <= '0;
      progress     <= '0;
      last_held    <= 8'd0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= ptr_next;
      end
      if (accept) begin
        p1_valid <= 1'b1;
      end else if (advance) begin
        p1_valid <= 1'b0;
      end
      if (advance) begin
        filled[p1_addr] <= 1'b1;
        running_sum     <= sum_next;
        result_valid    <= 1'b1;
        if (is_warm) begin
          progress  <= progress + 1'b1;
          last_held <= mean;
        end else begin
          if (is_forced) begin
            progress <= progress + 1'b1;
          end
          last_held <= held_next;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_sample <= sample;
      p1_addr   <= ptr;
      p1_filled <= filled[ptr];
    end
    if (advance) begin
      average       <= mean;
      change_amount <= is_warm ? 8'd0 : change;
      held_value    <= is_warm ? 8'd0 : held_next;
      warming       <= is_warm;
    end
  end

endmodule
